// File: rtl/bvg_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage gauge package
// Beat types, command struct, sequencer states, register indexes, LiPo table.
// ----------------------------------------------------------------------------
package bvg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int PCT_NUM_W   = 15;
    localparam int SPAN_W      = 8;
    localparam int LIPO_POINTS = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIVIDER_RATIO   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CELL_MV     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CELL_MV     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STALE_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HISTORY_INTERVAL = 3'd4;

    localparam logic [1:0] KIND_READING   = 2'd0;
    localparam logic [1:0] KIND_QUERY     = 2'd1;
    localparam logic [1:0] KIND_HIST_READ = 2'd2;

    localparam logic [15:0] LIPO_MV [LIPO_POINTS] = '{
        16'd4200, 16'd4060, 16'd3980, 16'd3920, 16'd3870, 16'd3820,
        16'd3790, 16'd3770, 16'd3740, 16'd3680, 16'd3450
    };
    localparam logic [6:0] LIPO_PCT [LIPO_POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd0
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [11:0] reading_mv;
        logic        burst_end;
        logic [6:0]  history_index;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] cell_mv;
        logic        battery_present;
        logic [6:0]  charge_percent;
        logic        reading_stale;
        logic [6:0]  history_value;
        logic        history_valid;
        logic [6:0]  history_filled;
    } t_out_beat;

    typedef struct packed {
        logic        wr_req;
        logic        rd_req;
        logic [31:0] now_ms;
        logic [6:0]  pct;
        logic [6:0]  rd_index;
    } t_hist_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_AVG,
        ST_MUL,
        ST_SCL,
        ST_QRY,
        ST_PCT,
        ST_HWR,
        ST_HRD,
        ST_FIN
    } t_state;

endpackage

// File: rtl/bvg_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per cycle; used for burst averages and table interpolation.
// ----------------------------------------------------------------------------
module bvg_div #(
    parameter int DIV_W = 16,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo
);

    localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DIV_W-1:0] r_quo;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        ge      = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == CNT_W'(DIV_W - 1)) |=> (r_done && !r_busy))
        else $error("divider missed its last step");
`endif

endmodule

// File: rtl/bvg_hist.sv
// ----------------------------------------------------------------------------
// History ring
// Interval-gated percent store with oldest-first reads and registered data.
// ----------------------------------------------------------------------------
module bvg_hist #(
    parameter int DEPTH = 96
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bvg_pkg::t_hist_cmd           i_cmd,
    input  logic [31:0]                  i_interval_ms,
    output logic [$clog2(DEPTH+1)-1:0]   o_entries,
    output logic [6:0]                   o_rd_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = ((IDX_W > 7) ? IDX_W : 7) + 1;

    logic [6:0]       r_mem [DEPTH];
    logic [IDX_W-1:0] r_slot;
    logic [CNT_W-1:0] r_entries;
    logic [31:0]      r_last_time;
    logic [6:0]       r_rd_data;

    logic [31:0]      age;
    logic             wr_en;
    logic [IDX_W-1:0] oldest;
    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] pos_wrap;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        age      = i_cmd.now_ms - r_last_time;
        wr_en    = i_cmd.wr_req && ((r_entries == '0) || (age >= i_interval_ms));
        oldest   = (r_entries < CNT_W'(DEPTH)) ? '0 : r_slot;
        pos_sum  = SUM_W'(oldest) + SUM_W'(i_cmd.rd_index);
        pos_wrap = (pos_sum >= SUM_W'(DEPTH)) ? (pos_sum - SUM_W'(DEPTH)) : pos_sum;
        rd_addr  = pos_wrap[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_entries   <= '0;
            r_last_time <= '0;
        end else if (wr_en) begin
            r_slot      <= (r_slot == IDX_W'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
            r_last_time <= i_cmd.now_ms;
            if (r_entries < CNT_W'(DEPTH)) begin
                r_entries <= r_entries + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_slot] <= i_cmd.pct;
        end
        if (i_cmd.rd_req) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_entries = r_entries;
    assign o_rd_data = r_rd_data;

`ifndef SYNTHESIS
    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries <= CNT_W'(DEPTH))
        else $error("history entry count beyond depth");

    a_first_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_req && r_entries == '0) |=> (r_entries == CNT_W'(1)))
        else $error("first history entry not recorded");
`endif

endmodule

// File: rtl/battery_voltage_gauge.sv
// ----------------------------------------------------------------------------
// Battery voltage gauge
// Burst-averaged divider readings scaled to cell millivolts, presence and
// LiPo percent queries, and an interval-gated percent history ring.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (t_in_beat)
//  out      output     o_out_valid / i_out_stall o_out_data (t_out_beat)
//  cfg      input      i_cfg_wr_en               i_cfg_index, i_cfg_data
//
//  A reading that does not end a burst only accumulates; a burst end runs
//  ST_AVG on the shared divider, then ST_MUL and ST_SCL. A query runs ST_QRY,
//  ST_PCT on the divider when it interpolates, ST_HWR if the cell is present,
//  then ST_FIN; a history read runs ST_HRD, then ST_FIN.
//  One beat is in work at a time; reset is synchronous and active low.
//  A stalled output holds in its register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module battery_voltage_gauge #(
    parameter int HISTORY_DEPTH = 96,
    parameter int BURST_LENGTH  = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  bvg_pkg::t_in_beat                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output bvg_pkg::t_out_beat                 o_out_data,
    input  logic                               i_cfg_wr_en,
    input  logic [bvg_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    localparam int CNT_W  = $clog2(BURST_LENGTH + 1);
    localparam int SUM_W  = 12 + CNT_W;
    localparam int DIV_W  = (SUM_W > bvg_pkg::PCT_NUM_W) ? SUM_W : bvg_pkg::PCT_NUM_W;
    localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int HCMP_W = (HCNT_W > 7) ? HCNT_W : 7;

    bvg_pkg::t_state    r_state;
    bvg_pkg::t_state    n_state;
    bvg_pkg::t_in_beat  r_in;
    bvg_pkg::t_out_beat r_out;
    logic               r_out_valid;

    logic [11:0] r_ratio;
    logic [15:0] r_min_mv;
    logic [15:0] r_max_mv;
    logic [31:0] r_stale_ms;
    logic [31:0] r_interval_ms;

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_cell_mv;
    logic [31:0]      r_last_time;
    logic [11:0]      r_avg;
    logic [23:0]      r_prod;
    logic             r_fresh;
    logic             r_present;
    logic [6:0]       r_pct;
    logic [6:0]       r_pct_base;
    logic             r_hit;

    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;

    logic              fresh;
    logic              present;
    logic              in_range;
    logic [15:0]       seg_lo_mv;
    logic [bvg_pkg::SPAN_W-1:0] seg_span;
    logic [6:0]        seg_rise;
    logic [6:0]        seg_lo_pct;
    logic [bvg_pkg::SPAN_W-1:0] seg_diff;
    logic [bvg_pkg::PCT_NUM_W-1:0] pct_num;

    logic                       accept;
    logic                       out_load;
    logic                       div_start;
    logic [DIV_W-1:0]           div_num;
    logic [bvg_pkg::SPAN_W-1:0] div_den;
    logic                       div_busy;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quo;

    bvg_pkg::t_hist_cmd hist_cmd;
    logic [HCNT_W-1:0]  hist_entries;
    logic [6:0]         hist_rd_data;

    bvg_div #(
        .DIV_W (DIV_W),
        .DEN_W (bvg_pkg::SPAN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    bvg_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (hist_cmd),
        .i_interval_ms (r_interval_ms),
        .o_entries     (hist_entries),
        .o_rd_data     (hist_rd_data)
    );

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (r_in.reading_mv != '0 && r_cnt < CNT_W'(BURST_LENGTH)) begin
            n_sum = r_sum + SUM_W'(r_in.reading_mv);
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_comb begin
        fresh    = (r_last_time != '0) && ((r_in.now_ms - r_last_time) <= r_stale_ms);
        present  = fresh && (r_cell_mv >= r_min_mv) && (r_cell_mv <= r_max_mv);
        in_range = (r_cell_mv < bvg_pkg::LIPO_MV[0]) &&
                   (r_cell_mv >= bvg_pkg::LIPO_MV[bvg_pkg::LIPO_POINTS-1]);
    end

    always_comb begin
        seg_lo_mv  = bvg_pkg::LIPO_MV[bvg_pkg::LIPO_POINTS-1];
        seg_span   = bvg_pkg::SPAN_W'(bvg_pkg::LIPO_MV[bvg_pkg::LIPO_POINTS-2] -
                                      bvg_pkg::LIPO_MV[bvg_pkg::LIPO_POINTS-1]);
        seg_rise   = bvg_pkg::LIPO_PCT[bvg_pkg::LIPO_POINTS-2] -
                     bvg_pkg::LIPO_PCT[bvg_pkg::LIPO_POINTS-1];
        seg_lo_pct = bvg_pkg::LIPO_PCT[bvg_pkg::LIPO_POINTS-1];
        for (int i = bvg_pkg::LIPO_POINTS - 1; i >= 1; i--) begin
            if (r_cell_mv >= bvg_pkg::LIPO_MV[i]) begin
                seg_lo_mv  = bvg_pkg::LIPO_MV[i];
                seg_span   = bvg_pkg::SPAN_W'(bvg_pkg::LIPO_MV[i-1] - bvg_pkg::LIPO_MV[i]);
                seg_rise   = bvg_pkg::LIPO_PCT[i-1] - bvg_pkg::LIPO_PCT[i];
                seg_lo_pct = bvg_pkg::LIPO_PCT[i];
            end
        end
        seg_diff = bvg_pkg::SPAN_W'(r_cell_mv - seg_lo_mv);
        pct_num  = bvg_pkg::PCT_NUM_W'(seg_diff) * bvg_pkg::PCT_NUM_W'(seg_rise);
    end

    assign accept   = i_in_valid && (r_state == bvg_pkg::ST_IDLE);
    assign out_load = (r_state == bvg_pkg::ST_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bvg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.kind)
                        bvg_pkg::KIND_READING:   n_state = bvg_pkg::ST_ACC;
                        bvg_pkg::KIND_QUERY:     n_state = bvg_pkg::ST_QRY;
                        bvg_pkg::KIND_HIST_READ: n_state = bvg_pkg::ST_HRD;
                        default:                 n_state = bvg_pkg::ST_IDLE;
                    endcase
                end
            end
            bvg_pkg::ST_ACC: begin
                if (r_in.burst_end && n_cnt != '0) begin
                    n_state = bvg_pkg::ST_AVG;
                end else begin
                    n_state = bvg_pkg::ST_IDLE;
                end
            end
            bvg_pkg::ST_AVG: begin
                if (div_done) begin
                    n_state = bvg_pkg::ST_MUL;
                end
            end
            bvg_pkg::ST_MUL: n_state = bvg_pkg::ST_SCL;
            bvg_pkg::ST_SCL: n_state = bvg_pkg::ST_IDLE;
            bvg_pkg::ST_QRY: begin
                if (!present) begin
                    n_state = bvg_pkg::ST_FIN;
                end else if (in_range) begin
                    n_state = bvg_pkg::ST_PCT;
                end else begin
                    n_state = bvg_pkg::ST_HWR;
                end
            end
            bvg_pkg::ST_PCT: begin
                if (div_done) begin
                    n_state = bvg_pkg::ST_HWR;
                end
            end
            bvg_pkg::ST_HWR: n_state = bvg_pkg::ST_FIN;
            bvg_pkg::ST_HRD: n_state = bvg_pkg::ST_FIN;
            bvg_pkg::ST_FIN: begin
                if (out_load) begin
                    n_state = bvg_pkg::ST_IDLE;
                end
            end
            default: n_state = bvg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != bvg_pkg::ST_IDLE);
        div_start  = 1'b0;
        div_num    = DIV_W'(n_sum);
        div_den    = bvg_pkg::SPAN_W'(n_cnt);
        hist_cmd.wr_req   = 1'b0;
        hist_cmd.rd_req   = 1'b0;
        hist_cmd.now_ms   = r_in.now_ms;
        hist_cmd.pct      = r_pct;
        hist_cmd.rd_index = r_in.history_index;
        case (r_state)
            bvg_pkg::ST_ACC: begin
                div_start = r_in.burst_end && (n_cnt != '0);
            end
            bvg_pkg::ST_QRY: begin
                div_start = present && in_range;
                div_num   = DIV_W'(pct_num);
                div_den   = seg_span;
            end
            bvg_pkg::ST_HWR: hist_cmd.wr_req = 1'b1;
            bvg_pkg::ST_HRD: hist_cmd.rd_req = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bvg_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_ratio       <= 12'd512;
            r_min_mv      <= 16'd3000;
            r_max_mv      <= 16'd4500;
            r_stale_ms    <= 32'd60000;
            r_interval_ms <= 32'd300000;
            r_sum         <= '0;
            r_cnt         <= '0;
            r_cell_mv     <= '0;
            r_last_time   <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    bvg_pkg::CFG_DIVIDER_RATIO:    r_ratio       <= i_cfg_data[11:0];
                    bvg_pkg::CFG_MIN_CELL_MV:      r_min_mv      <= i_cfg_data[15:0];
                    bvg_pkg::CFG_MAX_CELL_MV:      r_max_mv      <= i_cfg_data[15:0];
                    bvg_pkg::CFG_STALE_LIMIT:      r_stale_ms    <= i_cfg_data;
                    bvg_pkg::CFG_HISTORY_INTERVAL: r_interval_ms <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == bvg_pkg::ST_ACC) begin
                if (r_in.burst_end) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= n_sum;
                    r_cnt <= n_cnt;
                end
            end
            if (r_state == bvg_pkg::ST_SCL) begin
                r_cell_mv   <= r_prod[23:8];
                r_last_time <= (r_in.now_ms != '0) ? r_in.now_ms : 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (r_state == bvg_pkg::ST_AVG && div_done) begin
            r_avg <= div_quo[11:0];
        end
        if (r_state == bvg_pkg::ST_MUL) begin
            r_prod <= 24'(r_avg) * 24'(r_ratio);
        end
        if (r_state == bvg_pkg::ST_QRY) begin
            r_fresh    <= fresh;
            r_present  <= present;
            r_pct_base <= seg_lo_pct;
            r_pct      <= (present && r_cell_mv >= bvg_pkg::LIPO_MV[0]) ?
                          bvg_pkg::LIPO_PCT[0] : 7'd0;
        end
        if (r_state == bvg_pkg::ST_PCT && div_done) begin
            r_pct <= r_pct_base + 7'(div_quo[3:0]);
        end
        if (r_state == bvg_pkg::ST_HRD) begin
            r_hit <= (HCMP_W'(r_in.history_index) < HCMP_W'(hist_entries));
        end
        if (out_load) begin
            r_out.history_filled <= 7'(hist_entries);
            if (r_in.kind == bvg_pkg::KIND_QUERY) begin
                r_out.cell_mv         <= r_cell_mv;
                r_out.battery_present <= r_present;
                r_out.charge_percent  <= r_pct;
                r_out.reading_stale   <= !r_fresh;
                r_out.history_value   <= '0;
                r_out.history_valid   <= 1'b0;
            end else begin
                r_out.cell_mv         <= '0;
                r_out.battery_present <= 1'b0;
                r_out.charge_percent  <= '0;
                r_out.reading_stale   <= 1'b0;
                r_out.history_value   <= r_hit ? hist_rd_data : 7'd0;
                r_out.history_valid   <= r_hit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_cell_only_on_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bvg_pkg::ST_SCL) |=> $stable(r_cell_mv))
        else $error("cell voltage changed outside scaling step");

    a_percent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.charge_percent <= 7'd100))
        else $error("charge percent above full");

    a_absent_zero_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.battery_present) |->
        (o_out_data.charge_percent == 7'd0))
        else $error("percent reported without a present cell");

    a_div_busy_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == bvg_pkg::ST_AVG || r_state == bvg_pkg::ST_PCT))
        else $error("divider busy outside a divide step");
`endif

endmodule
